// ===== design/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CHECK_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a trigger implies a consequence on the next edge.
`define CHECK_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mlh_pkg.sv =====
`timescale 1ns / 1ps
package mlh_pkg;

	localparam int MAX_LINES_DEF = 512;
	localparam logic signed [63:0] HULL_INF = 64'sh3f3f3f3f3f3f3f3f;

	typedef enum logic [1:0] {
		ACT_CLEAR   = 2'd0,
		ACT_ADD     = 2'd1,
		ACT_SEARCH  = 2'd2,
		ACT_POINTER = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RD_TOP,
		RD_BELOW,
		RD_PTR
	} rdsel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CUT_RD,
		S_CUT_CHK,
		S_DIV,
		S_CUT_WR,
		S_CMP_RD,
		S_CMP,
		S_PUSH,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_MUL,
		S_ACC,
		S_FIN
	} state_t;

	typedef struct packed {
		logic   load_in;
		logic   do_clear;
		logic   rp_zero;
		logic   st_full;
		logic   st_empty;
		logic   rd_en;
		rdsel_t rd_sel;
		logic   div_start;
		logic   cut_wr;
		logic   pop;
		logic   push;
		logic   scan_init;
		logic   scan_adv;
		logic   mul;
		logic   acc;
		logic   out_load;
	} cmd_t;

	typedef struct packed {
		action_t action;
		logic    in_valid;
		logic    empty;
		logic    full;
		logic    ge2;
		logic    slope_eq;
		logic    div_done;
		logic    pop_ok;
		logic    scan_more;
		logic    out_free;
	} sts_t;

endpackage

// ===== design/mlh_ram.sv =====
`timescale 1ns / 1ps
module mlh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/mlh_div.sv =====
`timescale 1ns / 1ps
// Floor division of a 64-bit numerator by a 33-bit nonzero denominator,
// one quotient bit per cycle, then a sign fix-up step.
module mlh_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [32:0] den,
	output logic               done,
	output logic [63:0]        quot
);

	logic [63:0] dq_q;
	logic [31:0] ub_q;
	logic [31:0] rem_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        fix_q;
	logic        done_q;
	logic [63:0] res_q;
	logic [32:0] trial;
	logic        take;
	logic [32:0] den_abs;

	assign trial   = {rem_q, dq_q[63]};
	assign take    = trial >= {1'b0, ub_q};
	assign den_abs = den[32] ? 33'(-den) : den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				fix_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= num[63] ? 64'(-num) : 64'(num);
			ub_q  <= den_abs[31:0];
			rem_q <= '0;
			neg_q <= num[63] ^ den[32];
		end else if (busy_q) begin
			rem_q <= take ? 32'(trial - {1'b0, ub_q}) : trial[31:0];
			dq_q  <= {dq_q[62:0], take};
		end else if (fix_q) begin
			res_q <= neg_q ? (64'(0) - dq_q - {63'd0, rem_q != 32'd0}) : dq_q;
		end
	end

	assign done = done_q;
	assign quot = res_q;

endmodule

// ===== design/mlh_ctrl.sv =====
`timescale 1ns / 1ps
module mlh_ctrl
	import mlh_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  sts_t   sts,
	output cmd_t   cmd,
	output logic   in_ready
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.rd_sel = RD_TOP;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (sts.in_valid) begin
					cmd.load_in = 1'b1;
					unique case (sts.action)
						ACT_CLEAR: begin
							cmd.do_clear = 1'b1;
							state_d = S_FIN;
						end
						ACT_ADD: begin
							cmd.rp_zero = 1'b1;
							if (sts.full) begin
								cmd.st_full = 1'b1;
								state_d = S_FIN;
							end else if (sts.empty) begin
								state_d = S_PUSH;
							end else begin
								state_d = S_CUT_RD;
							end
						end
						default: begin
							if (sts.empty) begin
								cmd.st_empty = 1'b1;
								state_d = S_FIN;
							end else begin
								cmd.scan_init = 1'b1;
								state_d = S_SCAN_RD;
							end
						end
					endcase
				end
			end
			S_CUT_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_TOP;
				state_d = S_CUT_CHK;
			end
			S_CUT_CHK: begin
				if (sts.slope_eq) begin
					state_d = S_CUT_WR;
				end else begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_CUT_WR;
				end
			end
			S_CUT_WR: begin
				cmd.cut_wr = 1'b1;
				state_d = sts.ge2 ? S_CMP_RD : S_PUSH;
			end
			S_CMP_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_BELOW;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (sts.pop_ok) begin
					cmd.pop = 1'b1;
					state_d = S_CUT_RD;
				end else begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d = S_FIN;
			end
			S_SCAN_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_PTR;
				state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (sts.scan_more) begin
					cmd.scan_adv = 1'b1;
					state_d = S_SCAN_RD;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== design/mlh_dp.sv =====
`timescale 1ns / 1ps
module mlh_dp
	import mlh_pkg::*;
#(
	parameter int MAX_LINES = MAX_LINES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output sts_t         sts,
	input  logic         in_valid,
	input  logic [1:0]   in_action,
	input  logic [127:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [79:0]  out_data
);

	localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int DW = $clog2(MAX_LINES + 1);

	logic signed [31:0] k_q;
	logic signed [63:0] m_q;
	logic signed [31:0] x_q;
	logic               ptr_mode_q;
	logic [DW-1:0]      depth_q;
	logic [AW-1:0]      rp_q;
	logic [AW-1:0]      ptr_q;
	logic signed [63:0] bp_top_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] value_q;
	status_t            status_q;
	logic               out_valid_q;
	logic [63:0]        out_value_q;
	status_t            out_status_q;
	logic [9:0]         out_count_q;

	logic [DW-1:0]      top_d;
	logic [DW-1:0]      below_d;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic signed [31:0] slope_rd;
	logic signed [63:0] icpt_rd;
	logic signed [63:0] bp_rd;
	logic signed [63:0] cut_val;
	logic signed [63:0] bp_wdata;
	logic [63:0]        div_q;
	logic               div_done;
	logic signed [63:0] prod_w;
	logic [DW:0]        ptr_next;
	logic [AW-1:0]      rp_init;
	logic [DW+9:0]      count_ext;

	assign top_d   = depth_q - DW'(1);
	assign below_d = depth_q - DW'(2);

	always_comb begin
		case (cmd.rd_sel)
			RD_TOP:   raddr = top_d[AW-1:0];
			RD_BELOW: raddr = below_d[AW-1:0];
			default:  raddr = ptr_q;
		endcase
	end

	assign waddr    = cmd.push ? depth_q[AW-1:0] : top_d[AW-1:0];
	assign bp_wdata = cmd.push ? HULL_INF : cut_val;

	mlh_ram #(.WIDTH(32), .DEPTH(MAX_LINES)) u_slope (
		.clk(clk), .we(cmd.push), .waddr(waddr), .wdata(k_q),
		.re(cmd.rd_en), .raddr(raddr), .rdata(slope_rd)
	);

	mlh_ram #(.WIDTH(64), .DEPTH(MAX_LINES)) u_icpt (
		.clk(clk), .we(cmd.push), .waddr(waddr), .wdata(m_q),
		.re(cmd.rd_en), .raddr(raddr), .rdata(icpt_rd)
	);

	mlh_ram #(.WIDTH(64), .DEPTH(MAX_LINES)) u_bp (
		.clk(clk), .we(cmd.push | cmd.cut_wr), .waddr(waddr), .wdata(bp_wdata),
		.re(cmd.rd_en), .raddr(raddr), .rdata(bp_rd)
	);

	mlh_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(m_q - icpt_rd),
		.den(33'({slope_rd[31], slope_rd}) - 33'({k_q[31], k_q})),
		.done(div_done), .quot(div_q)
	);

	// Equal slopes settle the cut without division.
	always_comb begin
		if (slope_rd == k_q) begin
			cut_val = (icpt_rd > m_q) ? HULL_INF : -HULL_INF;
		end else begin
			cut_val = div_q;
		end
	end

	assign prod_w   = slope_rd * x_q;
	assign ptr_next = (DW + 1)'(ptr_q) + (DW + 1)'(1);
	assign rp_init  = ((DW + 1)'(rp_q) >= (DW + 1)'(depth_q)) ? '0 : rp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			rp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.do_clear) begin
				depth_q <= '0;
				rp_q    <= '0;
			end
			if (cmd.rp_zero) begin
				rp_q <= '0;
			end
			if (cmd.pop) begin
				depth_q <= depth_q - DW'(1);
			end
			if (cmd.push) begin
				depth_q <= depth_q + DW'(1);
			end
			if (cmd.scan_init && ptr_mode_q == 1'b0 && in_action == ACT_POINTER) begin
				rp_q <= rp_init;
			end
			if (cmd.scan_adv && ptr_mode_q) begin
				rp_q <= ptr_next[AW-1:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			k_q        <= in_data[31:0];
			m_q        <= in_data[95:32];
			x_q        <= in_data[127:96];
			ptr_mode_q <= 1'b0;
			value_q    <= '0;
			status_q   <= ST_OK;
		end
		if (cmd.st_full) begin
			status_q <= ST_FULL;
		end
		if (cmd.st_empty) begin
			status_q <= ST_EMPTY;
		end
		if (cmd.scan_init) begin
			ptr_mode_q <= (in_action == ACT_POINTER);
			ptr_q      <= (in_action == ACT_POINTER) ? rp_init : '0;
		end
		if (cmd.scan_adv) begin
			ptr_q <= ptr_next[AW-1:0];
		end
		if (cmd.cut_wr) begin
			bp_top_q <= cut_val;
		end
		if (cmd.mul) begin
			prod_q <= prod_w;
		end
		if (cmd.acc) begin
			value_q <= prod_q + icpt_rd;
		end
		if (cmd.out_load) begin
			out_value_q  <= value_q;
			out_status_q <= status_q;
			out_count_q  <= count_ext[9:0];
		end
	end

	assign count_ext = (DW + 10)'(depth_q);

	assign sts.action    = action_t'(in_action);
	assign sts.in_valid  = in_valid;
	assign sts.empty     = depth_q == '0;
	assign sts.full      = depth_q == DW'(MAX_LINES);
	assign sts.ge2       = depth_q >= DW'(2);
	assign sts.slope_eq  = slope_rd == k_q;
	assign sts.div_done  = div_done;
	assign sts.pop_ok    = bp_rd >= bp_top_q;
	assign sts.scan_more = (ptr_next < (DW + 1)'(depth_q)) && (bp_rd < 64'(x_q));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = {4'd0, out_count_q, out_status_q, out_value_q};

endmodule

// ===== design/max_line_hull_engine.sv =====
`timescale 1ns / 1ps
// Line stack for a monotone convex-hull-trick kernel.
// Requests enter on the s_axis channel: tuser carries the action (clear, add
// line, query by search, query with the monotone read pointer), tdata the
// slope, intercept and query point. Every request yields exactly one result on
// m_axis: the evaluated value, a status code and the line count afterwards.
// One request is worked at a time. A clear or an error result goes from the
// accept step straight to the output register load. An add to an empty stack
// pushes the line, then loads the output; each breakpoint cut adds a read, a
// slope check, a run of the bit-serial divider (equal slopes skip it) and a
// write, each check of the line below adds a read and a compare, and each
// popped line costs one more cut and check. A query reads, checks, multiplies,
// adds and loads the output, plus a read and check for every breakpoint entry
// it steps past. The divider and the single memory read port set these steps.
// Reset empties the stack and clears the read pointer; line memories are not
// cleared, as only entries below the depth are read.
// The result sits in an output register, so a new request is taken while the
// last result waits; a stall on m_axis then holds the engine at its final
// step until the register frees up.
module max_line_hull_engine
	import mlh_pkg::*;
#(
	parameter int MAX_LINES = MAX_LINES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] slope, [95:32] intercept, [127:96] query_point
	input  logic [127:0] s_axis_tdata,
	// [1:0] action
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [63:0] value, [65:64] status, [75:66] line_count, [79:76] zero
	output logic [79:0]  m_axis_tdata
);

`include "assert_macros.svh"

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	// Sequence the work of each request.
	mlh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .cmd(cmd), .in_ready(in_ready)
	);

	// Hold the stack, divider, multiplier and output register.
	mlh_dp #(.MAX_LINES(MAX_LINES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_valid(s_axis_tvalid), .in_action(s_axis_tuser), .in_data(s_axis_tdata),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
	);

	assign s_axis_tready = in_ready;

	`CHECK_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready,
		"request taken while another is in work")
	`CHECK_CLK(a_err_zero, m_axis_tvalid && m_axis_tdata[65:64] != ST_OK |->
		m_axis_tdata[63:0] == 64'd0, "error result carries a value")
	`CHECK_CLK(a_empty_count, m_axis_tvalid && m_axis_tdata[65:64] == ST_EMPTY |->
		m_axis_tdata[75:66] == 10'd0, "empty status with lines held")

endmodule

// ===== sim/max_line_hull_engine_tb.sv =====
`timescale 1ns / 1ps
module max_line_hull_engine_tb;
	import mlh_pkg::*;

	localparam int DEPTH = MAX_LINES_DEF;

	typedef struct {
		action_t     action;
		logic [31:0] slope;
		logic [63:0] intercept;
		logic [31:0] query_point;
	} request_t;

	typedef struct {
		logic [63:0] value;
		status_t     status;
		logic [9:0]  line_count;
	} result_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [79:0]  m_axis_tdata;

	max_line_hull_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// hull state as the block should hold it
	logic signed [63:0] hull_k [DEPTH];
	logic signed [63:0] hull_m [DEPTH];
	logic signed [63:0] hull_bp [DEPTH];
	int unsigned hull_depth;
	int unsigned hull_ptr;

	request_t pending_requests[$];
	result_t  expected_results[$];
	int  error_count;
	bit  hold_sender;
	bit  hold_receiver;
	int  send_gap;
	int  recv_gap;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("max_line_hull_engine_tb: errors");
		$finish;
	end

	function automatic logic signed [63:0] floor_quot(logic signed [63:0] a,
			logic signed [63:0] b);
		logic [63:0] ua;
		logic [63:0] ub;
		logic [63:0] q;
		logic [63:0] r;
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		q = ua / ub;
		r = ua % ub;
		if (a[63] == b[63])
			return q;
		return -q - (r != 0);
	endfunction

	// Recompute breakpoint of entry idx against the incoming line.
	function automatic void cut_line(int unsigned idx, logic signed [63:0] k,
			logic signed [63:0] m);
		if (hull_k[idx] == k) begin
			hull_bp[idx] = (hull_m[idx] > m) ? HULL_INF : -HULL_INF;
		end else begin
			hull_bp[idx] = floor_quot(m - hull_m[idx], hull_k[idx] - k);
		end
	endfunction

	function automatic result_t hull_apply(request_t rq);
		result_t rs;
		logic signed [63:0] k;
		logic signed [63:0] m;
		logic signed [63:0] x;
		int unsigned i;
		k = {{32{rq.slope[31]}}, rq.slope};
		m = rq.intercept;
		x = {{32{rq.query_point[31]}}, rq.query_point};
		rs.value = '0;
		rs.status = ST_OK;
		case (rq.action)
			ACT_CLEAR: begin
				hull_depth = 0;
				hull_ptr = 0;
			end
			ACT_ADD: begin
				hull_ptr = 0;
				if (hull_depth >= DEPTH) begin
					rs.status = ST_FULL;
				end else begin
					if (hull_depth > 0) begin
						cut_line(hull_depth - 1, k, m);
						while (hull_depth >= 2 &&
								hull_bp[hull_depth-2] >= hull_bp[hull_depth-1]) begin
							hull_depth--;
							cut_line(hull_depth - 1, k, m);
						end
					end
					hull_k[hull_depth] = k;
					hull_m[hull_depth] = m;
					hull_bp[hull_depth] = HULL_INF;
					hull_depth++;
				end
			end
			default: begin
				if (hull_depth == 0) begin
					rs.status = ST_EMPTY;
				end else if (rq.action == ACT_SEARCH) begin
					i = 0;
					while (i + 1 < hull_depth && hull_bp[i] < x)
						i++;
					rs.value = hull_k[i] * x + hull_m[i];
				end else begin
					if (hull_ptr >= hull_depth)
						hull_ptr = 0;
					while (hull_ptr + 1 < hull_depth && hull_bp[hull_ptr] < x)
						hull_ptr++;
					rs.value = hull_k[hull_ptr] * x + hull_m[hull_ptr];
				end
			end
		endcase
		rs.line_count = hull_depth[9:0];
		return rs;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(99) < 45)
			return 0;
		if ($urandom_range(99) < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic logic [31:0] rand_small32();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $urandom_range(2000);
			2: return -$urandom_range(2000);
			3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return $urandom_range(20) - 10;
		endcase
	endfunction

	function automatic logic [63:0] rand_icpt();
		case ($urandom_range(3))
			0: return {$urandom, $urandom};
			1: return {{32{1'b0}}, $urandom_range(1_000_000)};
			2: return -{{32{1'b0}}, $urandom_range(1_000_000)};
			default: return $urandom_range(1) ? 64'h7fffffffffffffff
				: 64'h8000000000000000;
		endcase
	endfunction

	task automatic queue_request(action_t a, logic [31:0] k, logic [63:0] m,
			logic [31:0] x);
		request_t rq;
		rq.action = a;
		rq.slope = k;
		rq.intercept = m;
		rq.query_point = x;
		pending_requests.insert(pending_requests.size(), rq);
	endtask

	// Driver: advance to the next request after each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			send_gap <= 0;
		end else if (!(s_axis_tvalid && !s_axis_tready)) begin
			if (s_axis_tvalid)
				expected_results.insert(expected_results.size(),
					hull_apply(pending_requests.pop_front()));
			if (send_gap > 0 || hold_sender || pending_requests.size() == 0
					|| (s_axis_tvalid && pick_gap() > 0 && $urandom_range(1))) begin
				s_axis_tvalid <= 1'b0;
				if (send_gap > 0)
					send_gap <= send_gap - 1;
				else if (s_axis_tvalid)
					send_gap <= pick_gap();
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= pending_requests[0].action;
				s_axis_tdata <= {pending_requests[0].query_point,
					pending_requests[0].intercept, pending_requests[0].slope};
			end
		end
	end

	// Monitor and receiver stalls.
	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, m_axis_tdata);
					error_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (m_axis_tdata[63:0] !== exp_r.value) begin
						$display("%0t: value exp %h got %h", $time, exp_r.value,
							m_axis_tdata[63:0]);
						error_count++;
					end
					if (m_axis_tdata[65:64] !== exp_r.status) begin
						$display("%0t: status exp %0d got %0d", $time, exp_r.status,
							m_axis_tdata[65:64]);
						error_count++;
					end
					if (m_axis_tdata[75:66] !== exp_r.line_count) begin
						$display("%0t: line_count exp %0d got %0d", $time,
							exp_r.line_count, m_axis_tdata[75:66]);
						error_count++;
					end
				end
			end
			if (hold_receiver) begin
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				m_axis_tready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else if (m_axis_tready && $urandom_range(3) == 0) begin
				m_axis_tready <= 1'b0;
				recv_gap <= pick_gap();
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic wait_drained();
		while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int n;
		int base;
		error_count = 0;
		hold_sender = 1'b0;
		hold_receiver = 1'b0;
		hull_depth = 0;
		hull_ptr = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty queries, equal slopes, extremes, overflow quotient
		queue_request(ACT_SEARCH, 0, 0, 5);
		queue_request(ACT_POINTER, 0, 0, 5);
		queue_request(ACT_ADD, 32'h80000000, 64'h8000000000000000, 0);
		queue_request(ACT_ADD, 32'h80000000, 64'h7fffffffffffffff, 0);
		queue_request(ACT_ADD, 32'h80000000, 64'h0, 0);
		queue_request(ACT_ADD, 32'h7fffffff, 64'h8000000000000000, 0);
		queue_request(ACT_SEARCH, 0, 0, 32'h80000000);
		queue_request(ACT_SEARCH, 0, 0, 32'h7fffffff);
		queue_request(ACT_POINTER, 0, 0, 32'hffffffff);
		queue_request(ACT_POINTER, 0, 0, 32'h7fffffff);
		queue_request(ACT_POINTER, 0, 0, 32'h80000000);
		queue_request(ACT_CLEAR, 32'hffffffff, 64'hffffffffffffffff, 32'hffffffff);
		queue_request(ACT_ADD, 32'hffffffff, 64'h8000000000000000, 0);
		queue_request(ACT_ADD, 0, 64'h0, 0);
		queue_request(ACT_ADD, 5, 64'd100, 0);
		queue_request(ACT_ADD, 5, 64'd50, 0);
		queue_request(ACT_SEARCH, 0, 0, 3);
		queue_request(ACT_POINTER, 0, 0, 1000);
		queue_request(ACT_CLEAR, 0, 0, 0);
		wait_drained();

		// fill the stack to the limit: ascending slopes on a concave curve keep every line
		for (int i = 0; i < DEPTH + 2; i++)
			queue_request(ACT_ADD, i, -(i * i), 0);
		queue_request(ACT_SEARCH, 0, 0, 100);
		queue_request(ACT_POINTER, 0, 0, 32'h7fffffff);
		// hold the receiver off while the sender keeps offering requests
		hold_receiver <= 1'b1;
		repeat (300) @(posedge clk);
		hold_receiver <= 1'b0;
		wait_drained();
		queue_request(ACT_CLEAR, 0, 0, 0);

		// random: sequences of adds then queries with random content, and random clears
		n = 0;
		while (n < 300) begin
			if ($urandom_range(9) == 0) begin
				queue_request(ACT_CLEAR, $urandom, {$urandom, $urandom}, $urandom);
				n++;
			end
			base = $urandom_range(1, 12);
			for (int j = 0; j < base; j++) begin
				if ($urandom_range(3) == 0)
					queue_request(ACT_ADD, rand_small32(), rand_icpt(), $urandom);
				else
					queue_request(ACT_ADD, j * 3 - 20 + $urandom_range(2),
						{{32{1'b0}}, $urandom_range(5000)} - 2500, $urandom);
				n++;
			end
			base = $urandom_range(1, 8);
			for (int j = 0; j < base; j++) begin
				queue_request($urandom_range(1) ? ACT_SEARCH : ACT_POINTER,
					$urandom, {$urandom, $urandom}, rand_small32());
				n++;
			end
			if (n > 150 && n < 180) begin
				// let the sender wait until every result is back
				wait_drained();
				hold_sender <= 1'b1;
				repeat (20) @(posedge clk);
				hold_sender <= 1'b0;
			end
		end
		wait_drained();
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("max_line_hull_engine_tb: clean");
		else
			$display("max_line_hull_engine_tb: errors");
		$finish;
	end

endmodule
